// ===== rtl/lpsc_pkg.sv =====
// lpsc_pkg: widths, register reset values, register index codes and the
// pipeline shape shared by the setpoint converter modules.
// No dependencies.
package lpsc_pkg;

  localparam int unsigned FreqW    = 24;
  localparam int unsigned DutyW    = 17;
  localparam int unsigned PsW      = 22;
  localparam int unsigned CntW     = 16;
  localparam int unsigned StepW    = 9;
  localparam int unsigned ClkW     = 32;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;

  // generator clock in MHz used for the dead-time conversion
  localparam int unsigned DeadClockMhzDef = 432;

  // divider: four stages, eight quotient bits each
  localparam int unsigned DivStages       = 4;
  localparam int unsigned DivBitsPerStage = ClkW / DivStages;

  // stage numbering: 1 prep, 2..5 divide and dead time, 6 clamp, 7 multiply, 8 output
  localparam int unsigned NumStages = DivStages + 4;

  localparam logic [DutyW-1:0] DutyOne = DutyW'(65536);

  localparam logic [ClkW-1:0]  RstCounterClock = 32'd3456000000;
  localparam logic [CntW-1:0]  RstMinCompare   = 16'd48;
  localparam logic [CntW-1:0]  RstPeriodMax    = 16'd65519;
  localparam logic [FreqW-1:0] RstMinRunFreq   = 24'd1000;
  localparam logic [StepW-1:0] RstDeadMin      = 9'd52;
  localparam logic [StepW-1:0] RstDeadMax      = 9'd388;

  typedef enum logic [CfgIdxW-1:0] {
    RegCounterClock = 3'd0,
    RegMinCompare   = 3'd1,
    RegPeriodMax    = 3'd2,
    RegMinRunFreq   = 3'd3,
    RegDeadMin      = 3'd4,
    RegDeadMax      = 3'd5
  } lpsc_reg_e;

  // side data that rides along the divider stages
  typedef struct packed {
    logic             run;
    logic [DutyW-1:0] duty;
  } lpsc_carry_t;

endpackage

// ===== rtl/lpsc_div_stage.sv =====
// lpsc_div_stage: one registered slice of the restoring period divider,
// resolving DivBitsPerStage quotient bits. Depends on lpsc_pkg.
module lpsc_div_stage (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [lpsc_pkg::FreqW-1:0]            dvs_i,
  input  logic [lpsc_pkg::FreqW-1:0]            rem_i,
  input  logic [lpsc_pkg::ClkW-1:0]             quo_i,
  input  logic [lpsc_pkg::DivBitsPerStage-1:0]  dvd_bits_i,
  output logic [lpsc_pkg::FreqW-1:0]            dvs_o,
  output logic [lpsc_pkg::FreqW-1:0]            rem_o,
  output logic [lpsc_pkg::ClkW-1:0]             quo_o
);
  import lpsc_pkg::*;

  logic [FreqW-1:0]           dvs_q, rem_d, rem_q;
  logic [ClkW-1:0]            quo_d, quo_q;
  logic [DivBitsPerStage-1:0] bits;
  logic [FreqW:0]             trial;

  // a zero divisor makes every bit one, which the period clamp then caps
  always_comb begin
    rem_d = rem_i;
    bits  = '0;
    trial = '0;
    for (int i = 0; i < DivBitsPerStage; i++) begin
      trial = {rem_d, dvd_bits_i[DivBitsPerStage-1-i]};
      if (trial >= {1'b0, dvs_i}) begin
        trial = trial - {1'b0, dvs_i};
        bits[DivBitsPerStage-1-i] = 1'b1;
      end
      rem_d = trial[FreqW-1:0];
    end
    quo_d = {quo_i[ClkW-DivBitsPerStage-1:0], bits};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvs_q <= dvs_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign dvs_o = dvs_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// ===== rtl/lpsc_dead_conv.sv =====
// lpsc_dead_conv: four-stage conversion of one leg's dead time from
// picoseconds to generator steps with ceiling and floor. Depends on lpsc_pkg.
module lpsc_dead_conv #(
  parameter int unsigned DeadClockMhz = lpsc_pkg::DeadClockMhzDef
) (
  input  logic                        clk_i,
  input  logic [3:0]                  en_i,
  input  logic [lpsc_pkg::PsW-1:0]    ps_i,
  input  logic [lpsc_pkg::StepW-1:0]  dead_min_i,
  input  logic [lpsc_pkg::StepW-1:0]  dead_max_i,
  output logic [lpsc_pkg::StepW-1:0]  steps_o
);
  import lpsc_pkg::*;

  localparam int unsigned     MulW       = $clog2(DeadClockMhz + 1);
  localparam int unsigned     XW         = PsW + MulW;
  localparam longint unsigned QMax       = ((64'd1 << PsW) - 64'd1) * DeadClockMhz / 64'd1000000;
  localparam int unsigned     QW         = $clog2(QMax + 2);
  localparam int unsigned     RecipShift = 40;
  localparam longint unsigned RecipL     = (64'd1 << RecipShift) / 64'd1000000;
  localparam int unsigned     RecipW     = $clog2(RecipL + 1);
  localparam int unsigned     PW         = XW + RecipW;
  localparam int unsigned     CmpW       = (QW > StepW) ? QW : StepW;

  localparam logic [MulW-1:0]   ClkMul  = MulW'(DeadClockMhz);
  localparam logic [RecipW-1:0] Recip   = RecipW'(RecipL);
  localparam logic [XW-1:0]     Million = XW'(1000000);

  logic          zero_a_q, zero_b_q, zero_c_q;
  logic [XW-1:0] x_a_q, x_b_q;
  logic [PW-1:0] est_prod;
  logic [QW-1:0] q0_b_q, q_c_q;
  logic [XW-1:0] qm, rem;
  logic [CmpW-1:0] q_ext, max_ext;
  logic [StepW-1:0] steps_d, steps_q;

  // reciprocal estimate is floor or one below; the remainder check fixes it
  assign est_prod = PW'(x_a_q) * PW'(Recip);
  assign qm       = XW'(q0_b_q) * Million;
  assign rem      = x_b_q - qm;

  always_comb begin
    q_ext   = CmpW'(q_c_q);
    max_ext = CmpW'(dead_max_i);
    if (zero_c_q || (q_ext > max_ext)) begin
      steps_d = dead_max_i;
    end else begin
      steps_d = StepW'(q_c_q);
    end
    if (steps_d < dead_min_i) begin
      steps_d = dead_min_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_a_q    <= XW'(ps_i) * XW'(ClkMul);
      zero_a_q <= (ps_i == '0);
    end
    if (en_i[1]) begin
      x_b_q    <= x_a_q;
      q0_b_q   <= est_prod[RecipShift +: QW];
      zero_b_q <= zero_a_q;
    end
    if (en_i[2]) begin
      q_c_q    <= q0_b_q + QW'(rem >= Million);
      zero_c_q <= zero_b_q;
    end
    if (en_i[3]) begin
      steps_q <= steps_d;
    end
  end

  assign steps_o = steps_q;

endmodule

// ===== rtl/llc_pwm_setpoint_converter_top.sv =====
// llc_pwm_setpoint_converter_top: eight-stage pipeline turning a bridge
// command into period, lag and dead-time settings.
// Depends on lpsc_pkg, lpsc_div_stage and lpsc_dead_conv.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  command  | in_valid_i / in_ready_o  | gate, freq_hz, duty_q16, dead_*_ps
//  settings | out_valid_o / out_ready_i| run, period_counts, lag_counts, dead_*_steps
//  config   | cfg_we_i (no wait)       | cfg_idx_i, cfg_data_i
//
// One command per cycle is accepted unless a stalled output has backed up the
// pipeline; each result passes through the prep stage, the 32-bit period divider,
// split into four stages of eight restoring steps, and then the clamp, multiply
// and lag stages before it is presented on the output.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage holds while its successor is full and stalled; bubbles collapse,
// so a stalled output still lets earlier stages fill.
module llc_pwm_setpoint_converter_top #(
  parameter int unsigned DeadClockMhz = lpsc_pkg::DeadClockMhzDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          gate_i,
  input  logic [lpsc_pkg::FreqW-1:0]    freq_hz_i,
  input  logic [lpsc_pkg::DutyW-1:0]    duty_q16_i,
  input  logic [lpsc_pkg::PsW-1:0]      dead_common_ps_i,
  input  logic [lpsc_pkg::PsW-1:0]      dead_leg_a_ps_i,
  input  logic [lpsc_pkg::PsW-1:0]      dead_leg_b_ps_i,
  // settings
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          run_o,
  output logic [lpsc_pkg::CntW-1:0]     period_counts_o,
  output logic [lpsc_pkg::CntW-1:0]     lag_counts_o,
  output logic [lpsc_pkg::StepW-1:0]    dead_a_steps_o,
  output logic [lpsc_pkg::StepW-1:0]    dead_b_steps_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [lpsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lpsc_pkg::CfgDataW-1:0] cfg_data_i
);
  import lpsc_pkg::*;

  localparam int unsigned ClampSt = DivStages + 2;
  localparam int unsigned MulSt   = DivStages + 3;
  localparam int unsigned ProdW   = DutyW + CntW;

  // ---------------------------------------------------------------- config
  logic [ClkW-1:0]  clk_hz_q;
  logic [CntW-1:0]  min_cmp_q, period_max_q;
  logic [FreqW-1:0] min_run_q;
  logic [StepW-1:0] dead_min_q, dead_max_q;

  // the user must change config only while the pipeline is empty (not enforced here), so every stage reads it live
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q     <= RstCounterClock;
      min_cmp_q    <= RstMinCompare;
      period_max_q <= RstPeriodMax;
      min_run_q    <= RstMinRunFreq;
      dead_min_q   <= RstDeadMin;
      dead_max_q   <= RstDeadMax;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCounterClock: clk_hz_q     <= cfg_data_i[ClkW-1:0];
        RegMinCompare:   min_cmp_q    <= cfg_data_i[CntW-1:0];
        RegPeriodMax:    period_max_q <= cfg_data_i[CntW-1:0];
        RegMinRunFreq:   min_run_q    <= cfg_data_i[FreqW-1:0];
        RegDeadMin:      dead_min_q   <= cfg_data_i[StepW-1:0];
        RegDeadMax:      dead_max_q   <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- stage control
  logic [NumStages:1]   v_q;
  logic [NumStages+1:1] en;

  // a stage advances when it is empty or its successor advances
  always_comb begin
    en[NumStages+1] = out_ready_i;
    for (int k = NumStages; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[NumStages];

  // ------------------------------------------------------ stage 1: prep
  logic [FreqW-1:0] s1_freq_q;
  logic [PsW-1:0]   s1_psa_q, s1_psb_q;
  lpsc_carry_t      car_q [1:DivStages+1];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      car_q[1].run  <= gate_i && (freq_hz_i >= min_run_q);
      car_q[1].duty <= (duty_q16_i > DutyOne) ? DutyOne : duty_q16_i;
      s1_freq_q     <= freq_hz_i;
      s1_psa_q      <= (dead_leg_a_ps_i != '0) ? dead_leg_a_ps_i : dead_common_ps_i;
      s1_psb_q      <= (dead_leg_b_ps_i != '0) ? dead_leg_b_ps_i : dead_common_ps_i;
    end
    // advance run and duty alongside the divider
    for (int k = 2; k <= DivStages + 1; k++) begin
      if (en[k]) begin
        car_q[k] <= car_q[k-1];
      end
    end
  end

  // --------------------------------------------- stages 2..5: divide
  logic [FreqW-1:0] dvs [0:DivStages];
  logic [FreqW-1:0] rem [0:DivStages];
  logic [ClkW-1:0]  quo [0:DivStages];

  assign dvs[0] = s1_freq_q;
  assign rem[0] = '0;
  assign quo[0] = '0;

  for (genvar i = 0; i < DivStages; i++) begin : g_div
    lpsc_div_stage u_div (
      .clk_i      (clk_i),
      .en_i       (en[i+2]),
      .dvs_i      (dvs[i]),
      .rem_i      (rem[i]),
      .quo_i      (quo[i]),
      .dvd_bits_i (clk_hz_q[ClkW-1-i*DivBitsPerStage -: DivBitsPerStage]),
      .dvs_o      (dvs[i+1]),
      .rem_o      (rem[i+1]),
      .quo_o      (quo[i+1])
    );
  end

  // dead times share stages 2..5
  logic [StepW-1:0] dead_a5, dead_b5;

  lpsc_dead_conv #(.DeadClockMhz(DeadClockMhz)) u_dead_a (
    .clk_i      (clk_i),
    .en_i       (en[DivStages+1:2]),
    .ps_i       (s1_psa_q),
    .dead_min_i (dead_min_q),
    .dead_max_i (dead_max_q),
    .steps_o    (dead_a5)
  );

  lpsc_dead_conv #(.DeadClockMhz(DeadClockMhz)) u_dead_b (
    .clk_i      (clk_i),
    .en_i       (en[DivStages+1:2]),
    .ps_i       (s1_psb_q),
    .dead_min_i (dead_min_q),
    .dead_max_i (dead_max_q),
    .steps_o    (dead_b5)
  );

  // ------------------------------------------------- stage 6: clamp
  logic [ClkW-1:0]  quo_f;
  logic [CntW:0]    lo_bound;
  logic [CntW-1:0]  period_d;

  assign quo_f    = quo[DivStages];
  assign lo_bound = {min_cmp_q, 1'b0};

  // lower clamp first, the upper clamp wins when the bounds cross
  always_comb begin
    logic [ClkW-1:0] p;
    p = quo_f;
    if (p < ClkW'(lo_bound)) begin
      p = ClkW'(lo_bound);
    end
    if (p > ClkW'(period_max_q)) begin
      p = ClkW'(period_max_q);
    end
    period_d = p[CntW-1:0];
  end

  logic             s6_run_q;
  logic [DutyW-1:0] s6_duty_q;
  logic [CntW-1:0]  s6_period_q;
  logic [StepW-1:0] s6_dead_a_q, s6_dead_b_q;

  always_ff @(posedge clk_i) begin
    if (en[ClampSt]) begin
      s6_run_q    <= car_q[DivStages+1].run;
      s6_duty_q   <= car_q[DivStages+1].duty;
      s6_period_q <= period_d;
      s6_dead_a_q <= dead_a5;
      s6_dead_b_q <= dead_b5;
    end
  end

  // ---------------------------------------------- stage 7: multiply
  logic             s7_run_q;
  logic [CntW-1:0]  s7_period_q;
  logic [ProdW-1:0] s7_prod_q;
  logic [StepW-1:0] s7_dead_a_q, s7_dead_b_q;

  always_ff @(posedge clk_i) begin
    if (en[MulSt]) begin
      s7_run_q    <= s6_run_q;
      s7_period_q <= s6_period_q;
      s7_prod_q   <= ProdW'(s6_duty_q) * ProdW'(s6_period_q);
      s7_dead_a_q <= s6_dead_a_q;
      s7_dead_b_q <= s6_dead_b_q;
    end
  end

  // ------------------------------------------- stage 8: lag, output
  logic [CntW-1:0] lag_raw, lag_d;

  // duty is Q1.16 and the lag is half of duty * period: drop 17 bits
  assign lag_raw = s7_prod_q[DutyW +: CntW];
  assign lag_d   = (lag_raw < min_cmp_q) ? min_cmp_q : lag_raw;

  logic             out_run_q;
  logic [CntW-1:0]  out_period_q, out_lag_q;
  logic [StepW-1:0] out_dead_a_q, out_dead_b_q;

  always_ff @(posedge clk_i) begin
    if (en[NumStages]) begin
      out_run_q    <= s7_run_q;
      out_period_q <= s7_run_q ? s7_period_q : '0;
      out_lag_q    <= s7_run_q ? lag_d : '0;
      out_dead_a_q <= s7_dead_a_q;
      out_dead_b_q <= s7_dead_b_q;
    end
  end

  assign run_o           = out_run_q;
  assign period_counts_o = out_period_q;
  assign lag_counts_o    = out_lag_q;
  assign dead_a_steps_o  = out_dead_a_q;
  assign dead_b_steps_o  = out_dead_b_q;

  // ------------------------------------------------------ assertions
  a_stop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !run_o) |-> (period_counts_o == '0 && lag_counts_o == '0))
    else $error("stopped bridge reports nonzero period or lag");

  a_lag_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && run_o) |-> (lag_counts_o >= min_cmp_q))
    else $error("lag below minimum compare");

  a_period_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && run_o) |-> (period_counts_o <= period_max_q))
    else $error("period above maximum");

  a_dead_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dead_a_steps_o >= dead_min_q && dead_b_steps_o >= dead_min_q))
    else $error("dead time below floor");

endmodule

// ===== sim/llc_pwm_setpoint_converter_top_test.sv =====
// Self-checking testbench for llc_pwm_setpoint_converter_top: streams bridge commands through
// the valid/ready pipeline under random stalls and checks every settings transfer in order.
// Depends on lpsc_pkg and the converter RTL only.
module llc_pwm_setpoint_converter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpsc_pkg::*;

  // spare register indexes: writes to these must leave every register alone
  localparam logic [CfgIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare7 = 3'd7;

  // cycles without any transfer before the run is declared hung
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct {
    logic             gate;
    logic [FreqW-1:0] freq_hz;
    logic [DutyW-1:0] duty_q16;
    logic [PsW-1:0]   dead_common_ps;
    logic [PsW-1:0]   dead_leg_a_ps;
    logic [PsW-1:0]   dead_leg_b_ps;
  } bridge_cmd_t;

  typedef struct {
    logic             run;
    logic [CntW-1:0]  period_counts;
    logic [CntW-1:0]  lag_counts;
    logic [StepW-1:0] dead_a_steps;
    logic [StepW-1:0] dead_b_steps;
  } timer_setting_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic                gate_i           = 1'b0;
  logic [FreqW-1:0]    freq_hz_i        = '0;
  logic [DutyW-1:0]    duty_q16_i       = '0;
  logic [PsW-1:0]      dead_common_ps_i = '0;
  logic [PsW-1:0]      dead_leg_a_ps_i  = '0;
  logic [PsW-1:0]      dead_leg_b_ps_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic                run_o;
  logic [CntW-1:0]     period_counts_o;
  logic [CntW-1:0]     lag_counts_o;
  logic [StepW-1:0]    dead_a_steps_o;
  logic [StepW-1:0]    dead_b_steps_o;
  logic                cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i        = '0;
  logic [CfgDataW-1:0] cfg_data_i       = '0;

  // local copy of the register file, updated together with each write
  logic [ClkW-1:0]  cfg_counter_clock = RstCounterClock;
  logic [CntW-1:0]  cfg_min_compare   = RstMinCompare;
  logic [CntW-1:0]  cfg_period_max    = RstPeriodMax;
  logic [FreqW-1:0] cfg_min_run_freq  = RstMinRunFreq;
  logic [StepW-1:0] cfg_dead_min      = RstDeadMin;
  logic [StepW-1:0] cfg_dead_max      = RstDeadMax;

  bridge_cmd_t    pending_cmds[$];      // commands waiting for the driver
  timer_setting_t expected_settings[$]; // predicted settings, oldest first
  bridge_cmd_t    cmd_on_bus;
  timer_setting_t oldest_setting;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_wait      = 0;
  int unsigned send_burst     = 0;
  int unsigned ready_wait     = 0;
  int unsigned recv_burst     = 0;
  int unsigned hold_len;

  llc_pwm_setpoint_converter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .gate_i           (gate_i),
    .freq_hz_i        (freq_hz_i),
    .duty_q16_i       (duty_q16_i),
    .dead_common_ps_i (dead_common_ps_i),
    .dead_leg_a_ps_i  (dead_leg_a_ps_i),
    .dead_leg_b_ps_i  (dead_leg_b_ps_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .run_o            (run_o),
    .period_counts_o  (period_counts_o),
    .lag_counts_o     (lag_counts_o),
    .dead_a_steps_o   (dead_a_steps_o),
    .dead_b_steps_o   (dead_b_steps_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Picoseconds to generator steps: a zero leg falls back to the common value,
  // zero time or an overlong one takes the ceiling, and the floor is applied last.
  function automatic logic [StepW-1:0] dead_to_steps(logic [PsW-1:0] leg_ps,
                                                     logic [PsW-1:0] common_ps);
    logic [PsW-1:0] ps;
    logic [63:0]    steps;
    ps    = (leg_ps != '0) ? leg_ps : common_ps;
    steps = (64'(ps) * 64'(DeadClockMhzDef)) / 64'd1000000;
    if (ps == '0 || steps > 64'(cfg_dead_max)) steps = 64'(cfg_dead_max);
    if (steps < 64'(cfg_dead_min)) steps = 64'(cfg_dead_min);
    return steps[StepW-1:0];
  endfunction

  function automatic timer_setting_t convert_setpoint(bridge_cmd_t c);
    timer_setting_t s;
    logic [63:0]    period;
    logic [63:0]    lag;
    logic [63:0]    duty;
    s.run  = c.gate && (c.freq_hz >= cfg_min_run_freq);
    period = '0;
    lag    = '0;
    if (s.run) begin
      // a zero frequency acts as an infinite quotient and lands on the ceiling
      if (c.freq_hz == '0) period = 64'(cfg_period_max);
      else period = 64'(cfg_counter_clock) / 64'(c.freq_hz);
      if (period < {cfg_min_compare, 1'b0}) period = 64'({cfg_min_compare, 1'b0});
      if (period > 64'(cfg_period_max)) period = 64'(cfg_period_max);
      duty = (c.duty_q16 > DutyOne) ? 64'(DutyOne) : 64'(c.duty_q16);
      lag  = (duty * period) >> 17;
      if (lag < 64'(cfg_min_compare)) lag = 64'(cfg_min_compare);
    end
    s.period_counts = period[CntW-1:0];
    s.lag_counts    = lag[CntW-1:0];
    s.dead_a_steps  = dead_to_steps(c.dead_leg_a_ps, c.dead_common_ps);
    s.dead_b_steps  = dead_to_steps(c.dead_leg_b_ps, c.dead_common_ps);
    return s;
  endfunction

  function automatic void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatch_count++;
    end
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: advance to the next queued command once the current one
  // transfers, and predict its settings at the transfer edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait  <= 0;
      send_burst <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) expected_settings.push_back(convert_setpoint(cmd_on_bus));
      if (send_wait != 0) begin
        send_wait  <= send_wait - 1;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cmd_on_bus        = pending_cmds.pop_front();
        gate_i           <= cmd_on_bus.gate;
        freq_hz_i        <= cmd_on_bus.freq_hz;
        duty_q16_i       <= cmd_on_bus.duty_q16;
        dead_common_ps_i <= cmd_on_bus.dead_common_ps;
        dead_leg_a_ps_i  <= cmd_on_bus.dead_leg_a_ps;
        dead_leg_b_ps_i  <= cmd_on_bus.dead_leg_b_ps;
        in_valid_i       <= 1'b1;
        // bursts keep the pipe full for a while with no gaps at all
        if (send_burst != 0) begin
          send_burst <= send_burst - 1;
        end else begin
          if ($urandom_range(0, 39) == 0) send_burst <= $urandom_range(20, 60);
          send_wait <= pick_gap();
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Settings monitor: check each transfer against the oldest prediction, and
  // drop ready at random, both right after a transfer and while idle.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_wait  <= 0;
      recv_burst  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_settings.size() == 0) begin
          $error("settings transfer with no command outstanding");
          mismatch_count++;
        end else begin
          oldest_setting = expected_settings.pop_front();
          compare_field("run", 32'(oldest_setting.run), 32'(run_o));
          compare_field("period_counts", 32'(oldest_setting.period_counts),
                        32'(period_counts_o));
          compare_field("lag_counts", 32'(oldest_setting.lag_counts), 32'(lag_counts_o));
          compare_field("dead_a_steps", 32'(oldest_setting.dead_a_steps),
                        32'(dead_a_steps_o));
          compare_field("dead_b_steps", 32'(oldest_setting.dead_b_steps),
                        32'(dead_b_steps_o));
        end
      end
      if (!out_ready_i) begin
        if (ready_wait == 0) out_ready_i <= 1'b1;
        else ready_wait <= ready_wait - 1;
      end else if (recv_burst != 0) begin
        if (out_valid_o) recv_burst <= recv_burst - 1;
      end else if (out_valid_o || $urandom_range(0, 15) == 0) begin
        hold_len = pick_gap();
        if (hold_len != 0) begin
          out_ready_i <= 1'b0;
          ready_wait  <= hold_len - 1;
        end else if ($urandom_range(0, 29) == 0) begin
          recv_burst <= $urandom_range(20, 60);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles in which neither channel transfers.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_cmd(logic gate, logic [FreqW-1:0] freq, logic [DutyW-1:0] duty,
                                  logic [PsW-1:0] dc, logic [PsW-1:0] da, logic [PsW-1:0] db);
    bridge_cmd_t c;
    c.gate           = gate;
    c.freq_hz        = freq;
    c.duty_q16       = duty;
    c.dead_common_ps = dc;
    c.dead_leg_a_ps  = da;
    c.dead_leg_b_ps  = db;
    pending_cmds.push_back(c);
  endfunction

  // Dead time spread: mostly around the ceiling, some that round to no
  // steps at all, some over the full field width.
  function automatic logic [PsW-1:0] random_ps();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return PsW'($urandom);
    if (r == 2) return PsW'($urandom_range(1, 2314));
    return PsW'($urandom_range(0, 1200000));
  endfunction

  // Frequencies aim at the run threshold and both period clamps of the
  // current settings, with plain wide-range values in between.
  function automatic void add_random_cmds(int unsigned count);
    logic [FreqW:0]   near;
    logic [63:0]      q;
    logic [FreqW-1:0] freq;
    logic [DutyW-1:0] duty;
    logic [PsW-1:0]   da;
    logic [PsW-1:0]   db;
    int unsigned      r;
    for (int unsigned n = 0; n < count; n++) begin
      r = $urandom_range(0, 9);
      case (r)
        0: begin
          near = {1'b0, cfg_min_run_freq} + (FreqW+1)'($urandom_range(0, 4));
          if (near < 2) freq = '0;
          else if (near - 2 > {1'b0, {FreqW{1'b1}}}) freq = '1;
          else freq = FreqW'(near - 2);
        end
        1: freq = FreqW'($urandom_range(0, 16));
        2: freq = FreqW'($urandom);
        3, 4: freq = FreqW'($urandom_range(20000, 600000));
        5: freq = FreqW'($urandom_range(1000000, 16777215));
        6: begin
          q    = 64'(cfg_counter_clock) / 64'($urandom_range(1, 70000));
          freq = (q > 64'(16777215)) ? '1 : FreqW'(q);
        end
        default: freq = FreqW'($urandom_range(1000, 300000));
      endcase
      r = $urandom_range(0, 9);
      if (r == 0) duty = '0;
      else if (r == 1) duty = DutyOne;
      else if (r == 2) duty = DutyW'($urandom);
      else duty = DutyW'($urandom_range(0, 65536));
      da = ($urandom_range(0, 2) == 0) ? '0 : random_ps();
      db = ($urandom_range(0, 2) == 0) ? '0 : random_ps();
      add_cmd($urandom_range(0, 7) != 0, freq, duty, random_ps(), da, db);
    end
  endfunction

  // Drain: wait for every command to transfer and every prediction to be met,
  // then let the clock run on past the pipeline depth before returning.
  task automatic settle();
    while (pending_cmds.size() != 0 || in_valid_i || expected_settings.size() != 0)
      @(posedge clk_i);
    repeat (NumStages + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      RegCounterClock: cfg_counter_clock = data[ClkW-1:0];
      RegMinCompare:   cfg_min_compare   = data[CntW-1:0];
      RegPeriodMax:    cfg_period_max    = data[CntW-1:0];
      RegMinRunFreq:   cfg_min_run_freq  = data[FreqW-1:0];
      RegDeadMin:      cfg_dead_min      = data[StepW-1:0];
      RegDeadMax:      cfg_dead_max      = data[StepW-1:0];
      default: ;
    endcase
  endtask

  // Write all six registers, with junk above the width of each one narrower than
  // the data bus, then hit the spare indexes, which must change nothing.
  task automatic load_config(logic [ClkW-1:0] clk_hz, logic [CntW-1:0] min_cmp,
                             logic [CntW-1:0] per_max, logic [FreqW-1:0] min_run,
                             logic [StepW-1:0] dead_min, logic [StepW-1:0] dead_max);
    logic [CfgDataW-1:0] junk;
    junk = $urandom;
    write_reg(RegCounterClock, clk_hz);
    write_reg(RegMinCompare, {junk[31:16], min_cmp});
    write_reg(RegPeriodMax, {junk[15:0], per_max});
    write_reg(RegMinRunFreq, {junk[31:24], min_run});
    junk = $urandom;
    write_reg(RegDeadMin, {junk[31:9], dead_min});
    write_reg(RegDeadMax, {junk[22:0], dead_max});
    write_reg(RegSpare6, $urandom);
    write_reg(RegSpare7, $urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [ClkW-1:0] rnd_clk;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: gate off still converts dead times, threshold edges,
    // both period clamps, duty saturation, dead-time fallback and rounding.
    add_cmd(1'b0, 24'd100000, 17'd32768, 22'd200000, '0, '0);
    add_cmd(1'b1, 24'd100000, 17'd32768, 22'd200000, 22'd150000, '0);
    add_cmd(1'b1, 24'd999, 17'd32768, 22'd200000, '0, 22'd300000);
    add_cmd(1'b1, 24'd1000, 17'd32768, 22'd200000, '0, '0);
    add_cmd(1'b1, 24'd52734, 17'd65536, 22'd200000, '0, '0);
    add_cmd(1'b1, '1, '1, '1, '1, '1);
    add_cmd(1'b1, '0, 17'd1000, 22'd100, '0, '0);
    add_cmd(1'b1, 24'd200000, '0, 22'd500000, '0, '0);
    add_cmd(1'b1, 24'd200000, 17'd65536, 22'd500000, '0, '0);
    add_cmd(1'b1, 24'd200000, 17'd65537, 22'd500000, '0, '0);
    add_cmd(1'b1, 24'd200000, 17'd40000, '0, '0, '0);
    add_cmd(1'b1, 24'd300000, 17'd20000, 22'd2315, 22'd1, 22'd2314);
    add_cmd(1'b1, 24'd300000, 17'd20000, 22'd898148, 22'd898149, 22'd900463);
    add_cmd(1'b0, '0, '0, '0, '0, '0);
    add_random_cmds(82);
    settle();

    // All registers at their lowest, the counter clock at 1: zero-frequency run, period ceiling of 0.
    load_config(32'd1, '0, '0, '0, '0, '0);
    add_cmd(1'b1, '0, 17'd65536, 22'd500000, '0, '0);
    add_cmd(1'b1, 24'd1, 17'd65536, '0, 22'd7, '0);
    add_cmd(1'b0, '0, '0, 22'd1, '0, '0);
    add_random_cmds(82);
    settle();

    // All registers at their highest: bounds crossed, run only at top frequency.
    load_config('1, '1, '1, '1, '1, '1);
    add_cmd(1'b1, '1, 17'd65536, 22'd1000, '0, '0);
    add_cmd(1'b1, 24'hFFFFFE, 17'd65536, 22'd1000, '0, '0);
    add_random_cmds(82);
    settle();

    // Slow counter clock: period clamps up at high frequencies, dead floor
    // above ceiling, zero frequency runs at the ceiling.
    load_config(32'd200000000, 16'd40, 16'd5000, '0, 9'd100, 9'd50);
    add_cmd(1'b1, '1, 17'd65536, 22'd90000, '0, '0);
    add_cmd(1'b1, 24'd1000, 17'd32768, 22'd900000, '0, '0);
    add_cmd(1'b1, '0, 17'd65536, '0, '0, '0);
    add_random_cmds(82);
    settle();

    // Crossed clamps with a lag floor above the period.
    load_config(RstCounterClock, 16'd3000, 16'd1000, 24'd20000, 9'd10, 9'd500);
    add_cmd(1'b1, 24'd100000, 17'd65536, 22'd1100000, '0, '0);
    add_random_cmds(82);
    settle();

    // Two random register sets.
    repeat (2) begin
      rnd_clk = $urandom;
      if (rnd_clk == '0) rnd_clk = 32'd1;
      load_config(rnd_clk, CntW'($urandom_range(0, 400)), CntW'($urandom),
                  FreqW'($urandom_range(0, 200000)), StepW'($urandom_range(0, 120)),
                  StepW'($urandom));
      add_random_cmds(82);
      settle();
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
